// ===== rtl/core/isd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_pkg
// Shared constants and types for the descending insertion sorter.
// ----------------------------------------------------------------------------
package isd_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } isd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic insert;   // accepted input item, insert or drop its value
        logic pop;      // output transfer, shift the chain up by one
    } isd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic             empty;
        logic             last_one;   // exactly one entry left
    } isd_stat_t;

endpackage

// ===== rtl/core/isd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_ctrl
// Load/emit sequencer: takes items until the end of a set, then drains it.
// ----------------------------------------------------------------------------
module isd_ctrl
    import isd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      is_last,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  isd_stat_t stat,
    output isd_cmd_t  cmd
);

    isd_state_t state_reg;
    isd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && is_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall && stat.last_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd.insert = 1'b0;
        cmd.pop    = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall   = 1'b0;
                cmd.insert = in_valid;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.pop   = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !stat.empty)
        else $error("emitting from an empty store");

    a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && is_last) |=> (state_reg == ST_EMIT))
        else $error("end of set did not start emission");

    a_final_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && stat.last_one) |=> (state_reg == ST_LOAD) && stat.empty)
        else $error("final transfer did not return to load");

endmodule

// ===== rtl/core/isd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_datapath
// Insertion chain of DEPTH cells, held in descending order, with fill count.
// ----------------------------------------------------------------------------
module isd_datapath
    import isd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  isd_cmd_t                     cmd,
    input  logic signed [DATA_WIDTH-1:0] value,
    output isd_stat_t                    stat,
    output logic signed [DATA_WIDTH-1:0] head,
    output logic                         dropped
);

    logic signed [DATA_WIDTH-1:0] cell_reg  [DEPTH];
    logic signed [DATA_WIDTH-1:0] cell_next [DEPTH];
    logic [CNT_W-1:0]             fill_reg;
    logic [CNT_W-1:0]             fill_next;
    logic                         dropped_reg;
    logic                         dropped_next;
    logic [DEPTH-1:0]             below;    // held entry strictly less than value
    logic [DEPTH-1:0]             at_fill;
    logic                         full;

    assign full = (fill_reg == CNT_W'(DEPTH));

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            below[i]   = (CNT_W'(i) < fill_reg) && (cell_reg[i] < value);
            at_fill[i] = (CNT_W'(i) == fill_reg);
        end
    end

    // every cell decides on its own: take the upper neighbor, the new value, or hold
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (cmd.insert && !full)
        begin
            if (below[0] || at_fill[0])
            begin
                cell_next[0] = value;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (below[i-1])
                begin
                    cell_next[i] = cell_reg[i-1];
                end
                else if (below[i] || at_fill[i])
                begin
                    cell_next[i] = value;
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        if (cmd.insert)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
            if (stat.last_one)
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    assign stat.empty    = (fill_reg == '0);
    assign stat.last_one = (fill_reg == CNT_W'(1));
    assign head          = cell_reg[0];
    assign dropped       = dropped_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond store depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && !full) |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("insert did not grow the store");

    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && full) |=> dropped_reg && $stable(fill_reg))
        else $error("drop into full store mishandled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg >= CNT_W'(2)) |-> !(cell_reg[0] < cell_reg[1]))
        else $error("head entries out of order");

endmodule

// ===== rtl/core/insertion_sort_descending_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_descending_top
// Descending insertion sorter of signed values, sets of up to DEPTH entries.
// ----------------------------------------------------------------------------
// Each input transfer inserts one signed value into a chain of DEPTH cells
// that compare against it in parallel, so one item is taken per cycle while loading.
// The item flagged is_last ends the set: the block then stalls its input and
// emits the n held values largest first, one per cycle when the output is not
// stalled, with last_out on the smallest. Equal values keep arrival order.
// Values that arrive once the store is full are dropped and overflow is set
// on every result of that set.
module insertion_sort_descending_top
    import isd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         last_out,
    output logic                         overflow
);

    isd_cmd_t  cmd;
    isd_stat_t stat;

    isd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_last   (is_last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    isd_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .value   (value),
        .stat    (stat),
        .head    (sorted_value),
        .dropped (overflow)
    );

    assign last_out = stat.last_one;

endmodule

// ===== dv/insertion_sort_descending_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_descending_top_test
// Self-checking testbench for the descending insertion sorter.
// ----------------------------------------------------------------------------
// Values go in as sets closed by is_last. A local sort model predicts every
// emitted result, and a scoreboard compares each output transfer against the
// oldest prediction. Covered: field extremes, equal values, a full store,
// dropped values (the closing item among them), random sets with bursty
// idling on both sides, a drain pause and a back-to-back stretch at the end.
// ----------------------------------------------------------------------------
module insertion_sort_descending_top_test;
    import isd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 160;
    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
        logic                         ovf;
    } sorted_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [DATA_WIDTH-1:0] value = '0;
    logic                         is_last = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;

    // sort model state
    logic signed [DATA_WIDTH-1:0] held_vals [DEPTH];
    int                           held_cnt = 0;
    bit                           spilled = 1'b0;

    sorted_result_t pending_sorted [$];
    int             err_count = 0;
    int             items_sent = 0;
    bit             idle_en = 1'b1;
    bit             sender_quiet = 1'b0;
    int             stall_left = 0;
    int             quiet_cycles = 0;

    insertion_sort_descending_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Insert into the model; ties go after equal entries.
    task automatic predict_sort(input logic signed [DATA_WIDTH-1:0] v, input logic last);
        int pos;
        sorted_result_t r;
        if (held_cnt < DEPTH)
        begin
            pos = held_cnt;
            while (pos > 0 && held_vals[pos-1] < v)
            begin
                held_vals[pos] = held_vals[pos-1];
                pos--;
            end
            held_vals[pos] = v;
            held_cnt++;
        end
        else
            spilled = 1'b1;
        if (last)
        begin
            for (int i = 0; i < held_cnt; i++)
            begin
                r.value = held_vals[i];
                r.last  = (i == held_cnt - 1);
                r.ovf   = spilled;
                pending_sorted.push_back(r);
            end
            held_cnt = 0;
            spilled  = 1'b0;
        end
    endtask

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(input logic signed [DATA_WIDTH-1:0] v, input logic last);
        if (idle_en && !sender_quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        is_last  <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_sort(v, last);
        items_sent++;
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
            1: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int len);
        sender_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_item(rand_value(), i == len - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        logic signed [DATA_WIDTH-1:0] mix [5];
        mix = '{0, -1, 1, VAL_MAX, VAL_MIN};
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
        foreach (mix[i])
            send_item(mix[i], i == 4);
        // equal values around a smaller one
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(5, 1'b1);
        // ascending input, reversed on output
        for (int i = -3; i <= 2; i++)
            send_item(i, i == 2);
    endtask

    task automatic test_full_store();
        // exactly full, no drop
        for (int i = 0; i < DEPTH; i++)
            send_item(rand_value(), i == DEPTH - 1);
        // overfull; the closing item itself is dropped
        for (int i = 0; i < DEPTH + 3; i++)
            send_item(rand_value(), i == DEPTH + 2);
        // overflow must not stick to the next set
        send_item(rand_value(), 1'b1);
    endtask

    task automatic test_random_sets(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 15) == 0)
                send_set($urandom_range(DEPTH - 2, DEPTH + 6));
            else
                send_set($urandom_range(1, 8));
        end
    endtask

    task automatic test_drain_pause();
        send_set($urandom_range(4, 12));
        wait_drained();
        send_set($urandom_range(1, 5));
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            send_set($urandom_range(1, 10));
            sender_quiet = 1'b1;
        end
        send_set(DEPTH + 1);
    endtask

    // receiver stall bursts and scoreboard
    always @(posedge clk)
    begin
        if (!idle_en)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 13) - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        sorted_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sorted.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", sorted_value);
                err_count++;
            end
            else
            begin
                exp_r = pending_sorted.pop_front();
                if (sorted_value !== exp_r.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d", exp_r.value, sorted_value);
                    err_count++;
                end
                if (last_out !== exp_r.last)
                begin
                    $error("last_out: expected %0b, actual %0b", exp_r.last, last_out);
                    err_count++;
                end
                if (overflow !== exp_r.ovf)
                begin
                    $error("overflow: expected %0b, actual %0b", exp_r.ovf, overflow);
                    err_count++;
                end
            end
        end
    end

    // watchdog: cycles without an input transfer or an expected output transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall)
            || (out_valid && !out_stall && pending_sorted.size() != 0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** insertion_sort_descending_top: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_full_store();
        test_random_sets(RANDOM_ITEMS / 2);
        test_drain_pause();
        test_random_sets(RANDOM_ITEMS / 2);
        test_back_to_back();

        in_valid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (err_count == 0)
            $display("** insertion_sort_descending_top: PASSED **");
        else
            $display("** insertion_sort_descending_top: FAILED **");
        $finish;
    end

endmodule
